/* rtl/multichannel_exponential_slew_macros.svh */
// assertion macros used by the slew bank back end (msc_back)
// expects clk and rst_n in the scope of each use
`ifndef MULTICHANNEL_EXPONENTIAL_SLEW_MACROS_SVH
`define MULTICHANNEL_EXPONENTIAL_SLEW_MACROS_SVH

// condition holds on every edge out of reset
`define MSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define MSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/msc_pkg.sv */
// types, codes and the root table for the multichannel exponential slew bank
// no dependencies
package msc_pkg;

  localparam logic [2:0] KIND_DECL = 3'd0;
  localparam logic [2:0] KIND_SET  = 3'd1;
  localparam logic [2:0] KIND_GET  = 3'd2;
  localparam logic [2:0] KIND_TICK = 3'd3;
  localparam logic [2:0] KIND_REL  = 3'd4;

  localparam int QDEPTH = 2;
  localparam logic [26:0] LOG2_100_Q24 = 27'd111465410;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [2:0] {
    OP_DECL, OP_SET, OP_GET, OP_TICK, OP_REL, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_GETR, S_TRD, S_TCHK, S_DIV, S_POW, S_SHR, S_MAG, S_APPLY
  } st_t;

  typedef struct packed {
    op_t                op;
    logic               ch_ok;
    logic [3:0]         chan;
    logic signed [31:0] number;
    logic [25:0]        slew;
    logic [19:0]        dt;
  } cmd_t;

  typedef logic [16:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v     = x;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in q30, each entry the floored root of the one before
  function automatic root_tab_t build_root_tab();
    root_tab_t t;
    logic [63:0] s;
    t[0] = 31'h2000_0000;
    for (int j = 1; j <= 16; j++) begin
      s    = isqrt64({33'd0, t[j-1]} << 30);
      t[j] = s[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

/* rtl/msc_front.sv */
// front end: takes input beats, decodes the kind and drops items that do nothing
// depends on msc_pkg
module msc_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [87:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  input  logic          q_full,
  output logic          q_push,
  output msc_pkg::cmd_t q_cmd
);
  import msc_pkg::*;

  logic [3:0] chan;
  logic       ch_ok;
  logic [19:0] dt;
  op_t        op;

  assign chan  = in_tdata[3:0];
  assign dt    = in_tdata[81:62];
  assign ch_ok = (int'(chan) < NUM_CHANNELS);

  always_comb begin
    unique case (in_tuser)
      KIND_DECL: op = ch_ok ? OP_DECL : OP_NOP;
      KIND_SET:  op = ch_ok ? OP_SET : OP_NOP;
      KIND_GET:  op = OP_GET;
      KIND_TICK: op = (dt != '0) ? OP_TICK : OP_NOP;
      KIND_REL:  op = OP_REL;
      default:   op = OP_NOP;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && (op != OP_NOP);

  always_comb begin
    q_cmd.op     = op;
    q_cmd.ch_ok  = ch_ok;
    q_cmd.chan   = chan;
    q_cmd.number = in_tdata[35:4];
    q_cmd.slew   = in_tdata[61:36];
    q_cmd.dt     = dt;
  end

endmodule

/* rtl/msc_queue.sv */
// short command queue between front end and execution back end
// depends on msc_pkg
module msc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  msc_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output msc_pkg::cmd_t rd_cmd
);
  import msc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PW:0] DEPTH_C = (PW + 1)'(QDEPTH);
  localparam logic [PW-1:0] LAST_C = PW'(QDEPTH - 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == DEPTH_C);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_cmd    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == LAST_C) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? ((rp_r == LAST_C) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

endmodule

/* rtl/msc_back.sv */
// back end: channel store, tick engine (divider, root power, gap scale) and result register
// depends on msc_pkg and multichannel_exponential_slew_macros.svh
module msc_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  msc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic          out_tuser
);
  import msc_pkg::*;
  `include "multichannel_exponential_slew_macros.svh"

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

  st_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [NUM_CHANNELS-1:0] present_r, present_nxt, latched_r, latched_nxt;
  logic [NUM_CHANNELS-1:0] gzero_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [38:0] ntk_r, ntk_nxt, quo_r, quo_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic [30:0] r_r, r_nxt;
  logic [3:0]  pb_r, pb_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [11:0] eps_r, eps_nxt;
  logic [32:0] nmag_r, nmag_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;

  logic signed [31:0] cur_mem [NUM_CHANNELS];
  logic signed [31:0] goal_mem [NUM_CHANNELS];
  logic [25:0]        gt_mem [NUM_CHANNELS];
  logic signed [31:0] cur_q, goal_q;
  logic [25:0]        gt_q;

  logic [CW-1:0] cidx, rd_addr, wr_addr;
  logic          tick_st, decl_we, cur_we, goal_we, next_ch;
  logic [31:0]   cur_wd, goal_wd;
  logic [46:0]   tk_prod;
  logic [27:0]   dif;
  logic [26:0]   rem_s;
  logic [61:0]   pw_prod;
  logic [62:0]   mg_prod;
  logic [32:0]   dlt;
  logic [31:0]   tmag;
  logic          big;
  logic [32:0]   upd;

  assign cidx    = CW'(cmd_r.chan);
  assign tick_st = (state_r == S_TRD) || (state_r == S_TCHK) || (state_r == S_DIV) ||
                   (state_r == S_POW) || (state_r == S_SHR) || (state_r == S_MAG) ||
                   (state_r == S_APPLY);
  assign rd_addr = tick_st ? cnt_r : cidx;
  assign wr_addr = tick_st ? cnt_r : cidx;

  assign tk_prod = 47'(cmd_r.dt) * 47'(LOG2_100_Q24);
  assign rem_s   = {rem_r, quo_r[38]};
  assign dif     = {1'b0, rem_s} - {2'b00, gt_q};
  assign big     = (quo_r[38:16] >= 23'd31);
  assign pw_prod = 62'(r_r) * 62'(ROOT_TAB[5'(5'd16 - {1'b0, pb_r})]);
  assign mg_prod = 63'(mag_r) * 63'(r_r);
  assign dlt     = {cur_q[31], cur_q} - {goal_q[31], goal_q};
  assign tmag    = goal_q[31] ? (32'd0 - goal_q) : goal_q;
  assign upd     = neg_r ? ({goal_q[31], goal_q} - nmag_r) : ({goal_q[31], goal_q} + nmag_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    present_nxt    = present_r;
    latched_nxt    = latched_r;
    cnt_nxt        = cnt_r;
    ntk_nxt        = ntk_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    r_nxt          = r_r;
    pb_nxt         = pb_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    eps_nxt        = eps_r;
    nmag_nxt       = nmag_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    q_pop          = 1'b0;
    decl_we        = 1'b0;
    cur_we         = 1'b0;
    goal_we        = 1'b0;
    cur_wd         = cmd_r.number;
    goal_wd        = cmd_r.number;
    next_ch        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_IDLE;
        unique case (cmd_r.op)
          OP_DECL: begin
            if (cmd_r.ch_ok) begin
              decl_we = 1'b1;
              if (!present_r[cidx] || !latched_r[cidx]) begin
                cur_we  = 1'b1;
                goal_we = 1'b1;
              end
              if (!present_r[cidx]) latched_nxt[cidx] = 1'b0;
              present_nxt[cidx] = 1'b1;
            end
          end
          OP_SET: begin
            if (cmd_r.ch_ok && present_r[cidx]) begin
              goal_we           = 1'b1;
              latched_nxt[cidx] = 1'b1;
              cur_we            = gzero_r[cidx];
            end
          end
          OP_GET:  state_nxt = S_GETR;
          OP_TICK: begin
            ntk_nxt   = tk_prod[46:8];
            cnt_nxt   = '0;
            state_nxt = S_TRD;
          end
          OP_REL:  latched_nxt = '0;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_GETR: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_user_nxt   = cmd_r.ch_ok && present_r[cidx];
          out_data_nxt   = out_user_nxt ? cur_q : '0;
          state_nxt      = S_IDLE;
        end
      end
      S_TRD: begin
        if (present_r[cnt_r]) state_nxt = S_TCHK;
        else next_ch = 1'b1;
      end
      S_TCHK: begin
        if (cur_q == goal_q) begin
          next_ch = 1'b1;
        end else if (gt_q == '0) begin
          cur_we  = 1'b1;
          cur_wd  = goal_q;
          next_ch = 1'b1;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = ntk_r;
          dcnt_nxt  = 6'd39;
          neg_nxt   = dlt[32];
          mag_nxt   = dlt[32] ? 32'(33'd0 - dlt) : dlt[31:0];
          eps_nxt   = (tmag[31:20] == '0) ? 12'd1 : tmag[31:20];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = dif[27] ? rem_s[25:0] : dif[25:0];
        quo_nxt  = {quo_r[37:0], !dif[27]};
        dcnt_nxt = dcnt_r - 6'd1;
        if (dcnt_r == 6'd1) begin
          r_nxt     = ONE_Q30;
          pb_nxt    = 4'd15;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        if (big) begin
          r_nxt     = '0;
          state_nxt = S_MAG;
        end else begin
          if (quo_r[pb_r]) r_nxt = pw_prod[60:30];
          if (pb_r == '0) state_nxt = S_SHR;
          else pb_nxt = pb_r - 4'd1;
        end
      end
      S_SHR: begin
        r_nxt     = r_r >> quo_r[20:16];
        state_nxt = S_MAG;
      end
      S_MAG: begin
        nmag_nxt  = mg_prod[62:30];
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cur_we  = 1'b1;
        cur_wd  = (nmag_r < {21'd0, eps_r}) ? goal_q : upd[31:0];
        next_ch = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (next_ch) begin
      if (cnt_r == LAST_CH) begin
        state_nxt = S_IDLE;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_TRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      present_r    <= '0;
      latched_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      latched_r    <= latched_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    ntk_r      <= ntk_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    r_r        <= r_nxt;
    pb_r       <= pb_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    eps_r      <= eps_nxt;
    nmag_r     <= nmag_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // channel store
  always_ff @(posedge clk) begin
    cur_q  <= cur_mem[rd_addr];
    goal_q <= goal_mem[rd_addr];
    gt_q   <= gt_mem[rd_addr];
    if (cur_we) cur_mem[wr_addr] <= cur_wd;
    if (goal_we) goal_mem[wr_addr] <= goal_wd;
    if (decl_we) begin
      gt_mem[wr_addr]  <= cmd_r.slew;
      gzero_r[wr_addr] <= (cmd_r.slew == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `MSC_ASSERT_ALWAYS(a_latch_present, (latched_r & ~present_r) == '0, "latch on absent channel")
  `MSC_ASSERT_IMP(a_pop_idle, q_pop, state_r == S_IDLE, "queue pop outside idle")
  `MSC_ASSERT_IMP(a_div_count, state_r == S_DIV, dcnt_r != 6'd0, "divider ran past its count")
  `MSC_ASSERT_IMP(a_tick_present, state_r == S_TCHK, present_r[cnt_r], "tick on absent channel")

endmodule

/* rtl/multichannel_exponential_slew.sv */
// top level of the multichannel exponential slew bank
// depends on msc_pkg, msc_front, msc_queue and msc_back
//
// channel  dir  tdata                                        tuser
// in_      in   channel, number, glide_us, dt (88 bits)      kind (3 bits)
// out_     out  value (32 bits)                              exists (1 bit)
//
// declare, set and release finish in the back end; get also waits for a free output register
// tick walks every channel in turn, skips absent ones and sends each moving channel with a
// nonzero glide through a 39-step restoring divider and up to 16 root-table multiply steps
// reset is synchronous and active low; the store needs no clearing pass
// a two-beat command queue lets input beats land while the back end works or
// while a result waits in the output register
module multichannel_exponential_slew #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // channel[3:0], number[35:4], glide_us[61:36], dt[81:62]
  input  logic [2:0]  in_tuser,  // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // value[31:0]
  output logic        out_tuser  // exists
);
  import msc_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic q_full, q_push, q_valid, q_pop;

  msc_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd)
  );

  msc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_cmd    (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_cmd    (q_cmd)
  );

  msc_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
